// ===== rtl/core/edf_tick_scheduler_top_macros.svh =====
// Assertion macros for the EDF tick scheduler.
// Used by edf_tick_scheduler_top; no other dependencies.
`ifndef EDF_TICK_SCHEDULER_TOP_MACROS_SVH
`define EDF_TICK_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define EDFTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define EDFTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EDFTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EDFTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/edfts_pkg.sv =====
// Shared constants, codes and types of the EDF tick scheduler.
// Used by edfts_cell and edf_tick_scheduler_top; no dependencies.
package edfts_pkg;

    localparam int MaxTasks = 16;
    localparam int SlotW    = $clog2(MaxTasks);
    localparam int CntW     = $clog2(MaxTasks + 1);
    localparam int TimeW    = 32;
    localparam int ExecW    = 16;
    localparam int DlW      = 16;
    localparam int ReqW     = 2;
    localparam int OutSlotW = 4;
    localparam int InDataW  = 64;
    localparam int OutDataW = 40;

    typedef enum logic [ReqW-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic             en;
        logic [SlotW-1:0] slot;
        logic [TimeW-1:0] arrival;
        logic [ExecW-1:0] exec;
        logic [DlW-1:0]   deadline;
    } load_t;

    typedef struct packed {
        logic             en;
        logic [SlotW-1:0] slot;
    } upd_t;

    typedef struct packed {
        logic             found;
        logic             last;
        logic [DlW-1:0]   deadline;
        logic [SlotW-1:0] slot;
    } cand_t;

endpackage

// ===== rtl/core/edfts_cell.sv =====
// One task slot of the scheduler chain: holds the task and passes the best candidate on.
// Depends on edfts_pkg.
module edfts_cell
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [edfts_pkg::SlotW-1:0]       my_idx,
    input  edfts_pkg::load_t                  load,
    input  logic                              clr,
    input  edfts_pkg::upd_t                   upd,
    input  logic [edfts_pkg::TimeW-1:0]       cur_time,
    input  edfts_pkg::cand_t                  cand_in,
    output edfts_pkg::cand_t                  cand_out
);

    logic [edfts_pkg::TimeW-1:0] arrival_reg;
    logic [edfts_pkg::DlW-1:0]   deadline_reg;
    logic [edfts_pkg::ExecW-1:0] remaining_reg;
    logic                        valid_reg;
    logic                        valid_next;
    logic                        done_reg;
    logic                        done_next;
    edfts_pkg::cand_t            cand_reg;
    edfts_pkg::cand_t            cand_next;
    logic                        load_hit;
    logic                        upd_hit;
    logic                        ready;
    logic                        take;

    assign load_hit = load.en && (load.slot == my_idx);
    assign upd_hit  = upd.en && (upd.slot == my_idx);
    assign ready    = valid_reg && !done_reg && (arrival_reg <= cur_time)
                      && (remaining_reg != '0);
    assign take     = ready && (!cand_in.found || (deadline_reg < cand_in.deadline));

    always_comb
    begin
        cand_next = cand_in;
        if (take)
        begin
            cand_next.found    = 1'b1;
            cand_next.last     = (remaining_reg == edfts_pkg::ExecW'(1));
            cand_next.deadline = deadline_reg;
            cand_next.slot     = my_idx;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        done_next  = done_reg;
        if (clr)
        begin
            valid_next = 1'b0;
            done_next  = 1'b0;
        end
        else if (load_hit)
        begin
            valid_next = 1'b1;
            done_next  = (load.exec == '0);
        end
        else if (upd_hit && (remaining_reg == edfts_pkg::ExecW'(1)))
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
            cand_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
            cand_reg  <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            arrival_reg   <= load.arrival;
            deadline_reg  <= load.deadline;
            remaining_reg <= load.exec;
        end
        else if (upd_hit)
        begin
            remaining_reg <= remaining_reg - edfts_pkg::ExecW'(1);
        end
    end

    assign cand_out = cand_reg;

endmodule

// ===== rtl/core/edf_tick_scheduler_top.sv =====
// Top level of the earliest-deadline-first tick scheduler: control and chain of slot cells.
// Depends on edfts_pkg, edfts_cell and edf_tick_scheduler_top_macros.svh.
//
// Channel   Direction  Contents
// s_axis    in         request word: tuser = kind, tdata = task fields
// m_axis    out        one result word per tick
//
// A load or clear word needs no scan. During a tick, the best candidate
// moves one cell per cycle along the chain of slot cells.
// The input is not ready while a tick scans or while its result waits for room.
// A finished result sits in the output register until taken.
// Reset is asynchronous; no clearing pass is needed after it.
`include "edf_tick_scheduler_top_macros.svh"

module edf_tick_scheduler_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] arrival_time, [47:32] exec_time, [63:48] deadline
    input  logic [edfts_pkg::InDataW-1:0]      s_axis_tdata,
    // [1:0] req_type
    input  logic [edfts_pkg::ReqW-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] tick_time, [32] idle, [36:33] task_slot, [37] task_finished,
    // [38] all_done, [39] zero
    output logic [edfts_pkg::OutDataW-1:0]     m_axis_tdata
);

    edfts_pkg::state_t                 state_reg;
    edfts_pkg::state_t                 state_next;
    logic [edfts_pkg::CntW-1:0]        scan_cnt_reg;
    logic [edfts_pkg::CntW-1:0]        scan_cnt_next;
    logic [edfts_pkg::CntW-1:0]        load_cnt_reg;
    logic [edfts_pkg::CntW-1:0]        load_cnt_next;
    logic [edfts_pkg::CntW-1:0]        fin_cnt_reg;
    logic [edfts_pkg::CntW-1:0]        fin_cnt_next;
    logic [edfts_pkg::TimeW-1:0]       time_reg;
    logic [edfts_pkg::TimeW-1:0]       time_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [edfts_pkg::TimeW-1:0]       out_time_reg;
    logic                              out_idle_reg;
    logic [edfts_pkg::OutSlotW-1:0]    out_slot_reg;
    logic                              out_fin_reg;
    logic                              out_all_reg;

    edfts_pkg::req_t                   req;
    logic                              in_acc;
    logic                              scan_done;
    edfts_pkg::load_t                  load;
    edfts_pkg::upd_t                   upd;
    logic                              clr;
    edfts_pkg::cand_t                  chain [edfts_pkg::MaxTasks+1];
    edfts_pkg::cand_t                  res;
    logic [edfts_pkg::SlotW+edfts_pkg::OutSlotW-1:0] sel_wide;

    assign req       = edfts_pkg::req_t'(s_axis_tuser);
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign res       = chain[edfts_pkg::MaxTasks];
    assign scan_done = (state_reg == edfts_pkg::ST_SCAN)
                       && (scan_cnt_reg == edfts_pkg::CntW'(edfts_pkg::MaxTasks))
                       && (!out_valid_reg || m_axis_tready);
    assign sel_wide  = (edfts_pkg::SlotW + edfts_pkg::OutSlotW)'(res.slot);

    assign chain[0] = '0;

    for (genvar i = 0; i < edfts_pkg::MaxTasks; i++)
    begin : g_cell
        edfts_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_idx   (edfts_pkg::SlotW'(i)),
            .load     (load),
            .clr      (clr),
            .upd      (upd),
            .cur_time (time_reg),
            .cand_in  (chain[i]),
            .cand_out (chain[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            edfts_pkg::ST_IDLE:
            begin
                if (in_acc && (req == edfts_pkg::REQ_TICK))
                begin
                    state_next = edfts_pkg::ST_SCAN;
                end
            end
            edfts_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = edfts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = edfts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == edfts_pkg::ST_IDLE);
        load.en       = in_acc && (req == edfts_pkg::REQ_LOAD)
                        && (load_cnt_reg < edfts_pkg::CntW'(edfts_pkg::MaxTasks));
        load.slot     = load_cnt_reg[edfts_pkg::SlotW-1:0];
        load.arrival  = s_axis_tdata[31:0];
        load.exec     = s_axis_tdata[47:32];
        load.deadline = s_axis_tdata[63:48];
        clr           = in_acc && (req == edfts_pkg::REQ_CLEAR);
        upd.en        = scan_done && res.found;
        upd.slot      = res.slot;
    end

    always_comb
    begin
        scan_cnt_next = '0;
        if (state_reg == edfts_pkg::ST_SCAN)
        begin
            if (scan_cnt_reg == edfts_pkg::CntW'(edfts_pkg::MaxTasks))
            begin
                scan_cnt_next = scan_cnt_reg;
            end
            else
            begin
                scan_cnt_next = scan_cnt_reg + edfts_pkg::CntW'(1);
            end
        end

        load_cnt_next = load_cnt_reg;
        fin_cnt_next  = fin_cnt_reg;
        time_next     = time_reg;
        if (clr)
        begin
            load_cnt_next = '0;
            fin_cnt_next  = '0;
            time_next     = '0;
        end
        else if (load.en)
        begin
            load_cnt_next = load_cnt_reg + edfts_pkg::CntW'(1);
            if (load.exec == '0)
            begin
                fin_cnt_next = fin_cnt_reg + edfts_pkg::CntW'(1);
            end
        end
        else if (scan_done)
        begin
            if (upd.en && res.last)
            begin
                fin_cnt_next = fin_cnt_reg + edfts_pkg::CntW'(1);
            end
            if (time_reg != '1)
            begin
                time_next = time_reg + edfts_pkg::TimeW'(1);
            end
        end

        out_valid_next = out_valid_reg && !m_axis_tready;
        if (scan_done)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= edfts_pkg::ST_IDLE;
            scan_cnt_reg  <= '0;
            load_cnt_reg  <= '0;
            fin_cnt_reg   <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            load_cnt_reg  <= load_cnt_next;
            fin_cnt_reg   <= fin_cnt_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_done)
        begin
            out_time_reg <= time_reg;
            out_idle_reg <= !res.found;
            out_slot_reg <= res.found ? sel_wide[edfts_pkg::OutSlotW-1:0] : '0;
            out_fin_reg  <= res.found && res.last;
            out_all_reg  <= (fin_cnt_next == load_cnt_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_all_reg, out_fin_reg, out_slot_reg, out_idle_reg,
                            out_time_reg};

    `EDFTS_ASSERT_IMP(a_fin_le_loaded, clk, rst_n, 1'b1, fin_cnt_reg <= load_cnt_reg)
    `EDFTS_ASSERT_IMP(a_idle_result, clk, rst_n, m_axis_tvalid && m_axis_tdata[32],
        (m_axis_tdata[36:33] == '0) && !m_axis_tdata[37])
    `EDFTS_ASSERT_NEXT(a_tick_scans, clk, rst_n, in_acc && (req == edfts_pkg::REQ_TICK),
        state_reg == edfts_pkg::ST_SCAN)

endmodule
